// File: src/itb_pkg.sv
package itb_pkg;

  // command codes carried in the input tuser
  localparam logic [3:0] CMD_SET         = 4'd0;
  localparam logic [3:0] CMD_RESTART     = 4'd1;
  localparam logic [3:0] CMD_RESUME      = 4'd2;
  localparam logic [3:0] CMD_STOP        = 4'd3;
  localparam logic [3:0] CMD_RESTART_ALL = 4'd4;
  localparam logic [3:0] CMD_RESUME_ALL  = 4'd5;
  localparam logic [3:0] CMD_STOP_ALL    = 4'd6;
  localparam logic [3:0] CMD_TICK        = 4'd7;
  localparam logic [3:0] CMD_QUERY       = 4'd8;

  // index value reported when no timer matches
  localparam logic signed [8:0] IDX_NONE = -9'sd1;

  localparam int IN_DATA_W   = 88;
  localparam int IN_USER_W   = 4;
  localparam int OUT_DATA_W  = 80;
  localparam int OUT_USER_W  = 2;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic one_upd;
    logic all_upd;
    logic scan;
    logic rd_en;
    logic rd_walk;
    logic cnt_clr;
    logic cnt_inc;
    logic hit_clr;
    logic load_out;
  } itb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_tick;
    logic in_all;
    logic is_tick;
    logic cnt_last;
    logic hits_any;
    logic hit_cur;
    logic hits_more;
    logic out_free;
  } itb_stat_t;

endpackage

// File: src/itb_ctrl.sv
module itb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  itb_pkg::itb_stat_t st,
  output itb_pkg::itb_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ONE    = 3'd1;
  localparam logic [2:0] S_ALL    = 3'd2;
  localparam logic [2:0] S_TSCAN  = 3'd3;
  localparam logic [2:0] S_TDRAIN = 3'd4;
  localparam logic [2:0] S_TFIND  = 3'd5;
  localparam logic [2:0] S_RD     = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.latch   = 1'b1;
          cmd.cnt_clr = 1'b1;
          if (st.in_tick) begin
            state_nxt = S_TSCAN;
          end else if (st.in_all) begin
            state_nxt = S_ALL;
          end else begin
            state_nxt = S_ONE;
          end
        end
      end
      S_ONE: begin
        cmd.one_upd = 1'b1;
        state_nxt   = S_RD;
      end
      S_ALL: begin
        cmd.all_upd = 1'b1;
        if (st.cnt_last) begin
          state_nxt = S_RD;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_TSCAN: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_walk = 1'b1;
        cmd.scan    = 1'b1;
        if (st.cnt_last) begin
          state_nxt = S_TDRAIN;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_TDRAIN: begin
        // last timer update lands here
        cmd.cnt_clr = 1'b1;
        state_nxt   = S_TFIND;
      end
      S_TFIND: begin
        if (!st.hits_any) begin
          state_nxt = S_OUT;
        end else if (st.hit_cur) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_walk = 1'b1;
          state_nxt   = S_OUT;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          cmd.hit_clr  = 1'b1;
          if (st.is_tick && st.hits_more) begin
            cmd.cnt_inc = 1'b1;
            state_nxt   = S_TFIND;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: src/itb_datapath.sv
module itb_datapath #(
  parameter int NUM_TIMERS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [itb_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic [itb_pkg::IN_USER_W-1:0]     in_tuser,
  input  itb_pkg::itb_cmd_t                 cmd,
  output itb_pkg::itb_stat_t                st,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [itb_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic [itb_pkg::OUT_USER_W-1:0]    out_tuser,
  output logic                              out_tlast
);

  localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(NUM_TIMERS - 1);
  localparam logic [8:0]    NT9      = 9'(NUM_TIMERS);

  // input fields
  logic [3:0]  in_cmd;
  logic [7:0]  in_index;
  logic [31:0] in_ival;
  logic [15:0] in_rep;
  logic [31:0] in_now;

  assign in_cmd   = in_tuser[3:0];
  assign in_index = in_tdata[7:0];
  assign in_ival  = in_tdata[39:8];
  assign in_rep   = in_tdata[55:40];
  assign in_now   = in_tdata[87:56];

  // latched command
  logic [3:0]  cmd_r;
  logic [7:0]  idx_r;
  logic        idx_ok_r;
  logic [31:0] ival_r;
  logic [15:0] rep_r;
  logic [31:0] loop_time_r;

  // timer state
  logic [47:0]           cfg_mem [NUM_TIMERS];
  logic [47:0]           run_mem [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] cfg_vld_r;
  logic [NUM_TIMERS-1:0] run_vld_r;
  logic [NUM_TIMERS-1:0] flags_r;
  logic [NUM_TIMERS-1:0] hits_r;

  // walk and read stage
  logic [AW-1:0] cnt_r;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] rd_addr_r;
  logic [47:0]   rd_cfg_r;
  logic [47:0]   rd_run_r;
  logic          rd_cvld_r;
  logic          rd_rvld_r;
  logic          upd_vld_r;
  logic [AW-1:0] upd_addr_r;

  logic [31:0] rd_ival;
  logic [15:0] rd_rep;
  logic [15:0] rd_count;
  logic [31:0] rd_last;

  // output register
  logic        out_vld_r;
  logic        out_fired_r;
  logic [7:0]  out_idx_r;
  logic [15:0] out_count_r;
  logic [31:0] out_ival_r;
  logic        out_act_r;
  logic [8:0]  out_fa_r;
  logic [8:0]  out_fi_r;
  logic        out_err_r;
  logic        out_last_r;

  logic                  is_tick;
  logic                  is_all;
  logic [NUM_TIMERS-1:0] cur_mask;
  logic [AW-1:0]         idx_addr;

  assign is_tick  = (cmd_r == itb_pkg::CMD_TICK);
  assign is_all   = cmd_r inside {itb_pkg::CMD_RESTART_ALL, itb_pkg::CMD_RESUME_ALL,
                                  itb_pkg::CMD_STOP_ALL};
  assign cur_mask = NUM_TIMERS'(1) << cnt_r;
  assign idx_addr = idx_r[AW-1:0];
  assign rd_addr  = cmd.rd_walk ? cnt_r : idx_addr;

  // unwritten entries read as zero
  assign rd_ival  = rd_cvld_r ? rd_cfg_r[47:16] : 32'd0;
  assign rd_rep   = rd_cvld_r ? rd_cfg_r[15:0]  : 16'd0;
  assign rd_count = rd_rvld_r ? rd_run_r[47:32] : 16'd0;
  assign rd_last  = rd_rvld_r ? rd_run_r[31:0]  : 32'd0;

  // status to the controller
  always_comb begin
    st.in_tick   = (in_cmd == itb_pkg::CMD_TICK);
    st.in_all    = in_cmd inside {itb_pkg::CMD_RESTART_ALL, itb_pkg::CMD_RESUME_ALL,
                                  itb_pkg::CMD_STOP_ALL};
    st.is_tick   = is_tick;
    st.cnt_last  = (cnt_r == LAST_IDX);
    st.hits_any  = |hits_r;
    st.hit_cur   = hits_r[cnt_r];
    st.hits_more = |(hits_r & ~cur_mask);
    st.out_free  = !out_vld_r || out_tready;
  end

  // write port selection for the stores and flag updates
  logic          rw_en;
  logic [AW-1:0] rw_addr;
  logic [15:0]   rw_count;
  logic          cw_en;
  logic          fl_set;
  logic          fl_clr;
  logic [AW-1:0] fl_addr;
  logic          hit_set;
  logic [31:0]   elapsed;
  logic [15:0]   count_inc;

  assign elapsed   = loop_time_r - rd_last;
  assign count_inc = rd_count + 16'd1;

  always_comb begin
    rw_en    = 1'b0;
    rw_addr  = cnt_r;
    rw_count = 16'd0;
    cw_en    = 1'b0;
    fl_set   = 1'b0;
    fl_clr   = 1'b0;
    fl_addr  = cnt_r;
    hit_set  = 1'b0;
    if (cmd.one_upd && idx_ok_r) begin
      rw_addr = idx_addr;
      fl_addr = idx_addr;
      case (cmd_r)
        itb_pkg::CMD_SET: begin
          cw_en  = 1'b1;
          rw_en  = 1'b1;
          fl_set = 1'b1;
        end
        itb_pkg::CMD_RESTART: begin
          rw_en  = 1'b1;
          fl_set = 1'b1;
        end
        itb_pkg::CMD_RESUME: fl_set = 1'b1;
        itb_pkg::CMD_STOP:   fl_clr = 1'b1;
        default: ;
      endcase
    end else if (cmd.all_upd) begin
      case (cmd_r)
        itb_pkg::CMD_RESTART_ALL: begin
          rw_en  = 1'b1;
          fl_set = 1'b1;
        end
        itb_pkg::CMD_RESUME_ALL: fl_set = 1'b1;
        default:                 fl_clr = 1'b1;
      endcase
    end else if (upd_vld_r) begin
      // tick: fire a due active timer
      rw_addr  = upd_addr_r;
      fl_addr  = upd_addr_r;
      rw_count = count_inc;
      if (flags_r[upd_addr_r] && (elapsed >= rd_ival)) begin
        rw_en   = 1'b1;
        hit_set = 1'b1;
        if ((rd_rep != 16'd0) && (count_inc >= rd_rep)) begin
          fl_clr = 1'b1;
        end
      end
    end
  end

  // command latch
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loop_time_r <= 32'd0;
    end else if (cmd.latch && st.in_tick) begin
      loop_time_r <= in_now;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_r    <= in_cmd;
      idx_r    <= in_index;
      idx_ok_r <= ({1'b0, in_index} < NT9);
      ival_r   <= in_ival;
      rep_r    <= in_rep;
    end
  end

  // store arrays with registered read
  always_ff @(posedge clk) begin
    if (cw_en) begin
      cfg_mem[rw_addr] <= {ival_r, rep_r};
    end
    if (rw_en) begin
      run_mem[rw_addr] <= {rw_count, loop_time_r};
    end
    if (cmd.rd_en) begin
      rd_cfg_r  <= cfg_mem[rd_addr];
      rd_run_r  <= run_mem[rd_addr];
      rd_cvld_r <= cfg_vld_r[rd_addr];
      rd_rvld_r <= run_vld_r[rd_addr];
      rd_addr_r <= rd_addr;
    end
    upd_addr_r <= cnt_r;
  end

  // valid bits, flags, hits, walk counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_vld_r <= '0;
      run_vld_r <= '0;
      flags_r   <= '0;
      hits_r    <= '0;
      cnt_r     <= '0;
      upd_vld_r <= 1'b0;
    end else begin
      if (cw_en) begin
        cfg_vld_r[rw_addr] <= 1'b1;
      end
      if (rw_en) begin
        run_vld_r[rw_addr] <= 1'b1;
      end
      if (fl_set) begin
        flags_r[fl_addr] <= 1'b1;
      end else if (fl_clr) begin
        flags_r[fl_addr] <= 1'b0;
      end
      if (cmd.latch) begin
        hits_r <= '0;
      end else if (hit_set) begin
        hits_r[upd_addr_r] <= 1'b1;
      end else if (cmd.hit_clr) begin
        hits_r <= hits_r & ~cur_mask;
      end
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + AW'(1);
      end
      upd_vld_r <= cmd.scan;
    end
  end

  // lowest active and inactive index
  logic [8:0] first_act;
  logic [8:0] first_inact;

  always_comb begin
    first_act   = itb_pkg::IDX_NONE;
    first_inact = itb_pkg::IDX_NONE;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (flags_r[i]) begin
        first_act = 9'(i);
      end else begin
        first_inact = 9'(i);
      end
    end
  end

  // result assembly
  logic have;
  assign have = is_tick ? (|hits_r) : idx_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_fired_r <= is_tick && (|hits_r);
      out_idx_r   <= is_tick ? ((|hits_r) ? 8'(cnt_r) : 8'd0) : idx_r;
      out_count_r <= have ? rd_count : 16'd0;
      out_ival_r  <= have ? rd_ival : 32'd0;
      out_act_r   <= have && flags_r[rd_addr_r];
      out_fa_r    <= first_act;
      out_fi_r    <= first_inact;
      out_err_r   <= !is_tick && !is_all && !idx_ok_r;
      out_last_r  <= is_tick ? !st.hits_more : 1'b1;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'd0, out_fi_r, out_fa_r, out_act_r, out_ival_r, out_count_r,
                       out_idx_r};
  assign out_tuser  = {out_err_r, out_fired_r};
  assign out_tlast  = out_last_r;

endmodule

// File: src/interval_timer_bank.sv
// Bank of NUM_TIMERS interval timers driven by a command stream.
// Input channel (in_*): one command per transfer; in_tuser holds the command
// code, in_tdata the timer index, interval, repeat limit and tick time.
// Result channel (out_*): one or more transfers per command, out_tlast marks
// the final result of a command; out_tuser flags a firing and an index error.
// Command sequence, with the output not stalled:
//   set/restart/resume/stop/query: the command is latched, the timer updated
//   (none for a query), the store read and the result registered, in order
//   restart/resume/stop all: one timer per cycle, then read and result as above
//   tick: the timers are scanned with one store read per cycle through
//   the single read port, each update in the cycle after its read; then
//   the timers are searched in index order and each firing is read from
//   the store and reported as one result
// A command is taken only when the previous one has loaded its last result.
// The result register accepts a new result in the cycle the old one is
// taken, so a stalled receiver simply holds the sequencer in place.
// Reset (rst_n low, synchronous) clears all timers, flags and the stored
// tick time; no clearing pass is needed, commands are taken right away.
module interval_timer_bank #(
  parameter int NUM_TIMERS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // timer_index[7:0], interval_ms[39:8], repeat_limit[55:40], now_ms[87:56]
  input  logic [itb_pkg::IN_DATA_W-1:0]  in_tdata,
  // command[3:0]
  input  logic [itb_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // result_index[7:0], fire_count[23:8], interval_out[55:24], is_active[56],
  // first_active[65:57], first_inactive[74:66], zero fill[79:75]
  output logic [itb_pkg::OUT_DATA_W-1:0] out_tdata,
  // fired[0], index_error[1]
  output logic [itb_pkg::OUT_USER_W-1:0] out_tuser,
  output logic                           out_tlast
);

  itb_pkg::itb_cmd_t  cmd;
  itb_pkg::itb_stat_t st;

  // sequencer
  itb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  // timer stores and result register
  itb_datapath #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .st         (st),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
